// File: rtl/afsc_pkg.sv
// Package for the accent-folding, space-collapsing key generator.
// Holds byte constants, the per-item result group type and the folding functions.
// No dependencies.
`default_nettype none

package afsc_pkg;

  // Byte codes that the folding logic treats specially.
  localparam logic [7:0] LEAD_BYTE  = 8'hC3;
  localparam logic [7:0] SPACE_BYTE = 8'h20;
  localparam logic [7:0] TAB_BYTE   = 8'h09;
  localparam logic [7:0] LF_BYTE    = 8'h0A;
  localparam logic [7:0] CR_BYTE    = 8'h0D;
  localparam logic [7:0] UPPER_A    = 8'h41;
  localparam logic [7:0] UPPER_Z    = 8'h5A;
  localparam logic [7:0] CASE_DELTA = 8'h20;
  localparam logic [7:0] NO_BASE    = 8'h00;

  // Queue between the front and the back.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Maximum results caused by one input byte.
  localparam int MAX_RES = 3;

  // All results caused by one input byte, in output order.
  typedef struct packed {
    logic [1:0]              cnt;   // number of results, 1 to 3
    logic [MAX_RES-1:0][7:0] data;  // result bytes, slot 0 first
    logic                    eos;   // last result closes the string
    logic                    bare;  // single end marker without a byte
  } afsc_group_t;

  // Base letter of the second byte of a 0xC3 pair, or NO_BASE if unmapped.
  function automatic logic [7:0] accent_base(input logic [7:0] d);
    logic [7:0] r;
    r = NO_BASE;
    if ((d >= 8'h80 && d <= 8'h85) || (d >= 8'hA0 && d <= 8'hA5)) r = 8'h61;
    else if (d == 8'h87 || d == 8'hA7) r = 8'h63;
    else if ((d >= 8'h88 && d <= 8'h8B) || (d >= 8'hA8 && d <= 8'hAB)) r = 8'h65;
    else if ((d >= 8'h8C && d <= 8'h8F) || (d >= 8'hAC && d <= 8'hAF)) r = 8'h69;
    else if (d == 8'h91 || d == 8'hB1) r = 8'h6E;
    else if ((d >= 8'h92 && d <= 8'h96) || (d >= 8'hB2 && d <= 8'hB6)) r = 8'h6F;
    else if ((d >= 8'h99 && d <= 8'h9C) || (d >= 8'hB9 && d <= 8'hBC)) r = 8'h75;
    return r;
  endfunction

  // Fold a byte that is not part of a mapped pair.
  function automatic logic [7:0] fold_single(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= UPPER_A && c <= UPPER_Z) r = c + CASE_DELTA;
    else if (c == TAB_BYTE || c == CR_BYTE || c == LF_BYTE) r = SPACE_BYTE;
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/afsc_front.sv
// Front part: accepts input bytes, folds them and forms the result group.
// Depends on afsc_pkg.
`default_nettype none

module afsc_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [7:0]          in_byte,
  input  wire logic                in_is_last,
  input  wire logic                q_full,
  output logic                     q_push,
  output afsc_pkg::afsc_group_t    q_wdata
);
  import afsc_pkg::*;

  logic       lead_pending_r, lead_pending_nxt;
  logic       space_pending_r, space_pending_nxt;
  logic       output_started_r, output_started_nxt;
  logic       accept;
  logic [7:0] base;
  logic       handled;
  logic [1:0] em_v;
  logic [7:0] em_c [2];
  logic       sp;
  logic       os;
  logic [1:0] cnt;
  logic [7:0] slot [4];
  logic       lead_hold;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // A held lead byte resolves first; unless the current byte pairs with it, that byte is folded on its own or held.
  always_comb begin
    base      = accent_base(in_byte);
    handled   = lead_pending_r && (base != NO_BASE);
    lead_hold = !handled && (in_byte == LEAD_BYTE) && !in_is_last;
    em_v[0]   = lead_pending_r;
    em_c[0]   = handled ? base : LEAD_BYTE;
    em_v[1]   = !handled && !lead_hold;
    em_c[1]   = fold_single(in_byte);

    sp  = space_pending_r;
    os  = output_started_r;
    cnt = 2'd0;
    for (int i = 0; i < 4; i++) begin
      slot[i] = 8'h00;
    end
    // Space collapser over the two possible folded bytes.
    for (int i = 0; i < 2; i++) begin
      if (em_v[i]) begin
        if (em_c[i] == SPACE_BYTE) begin
          if (os) sp = 1'b1;
        end else begin
          if (sp) begin
            slot[cnt] = SPACE_BYTE;
            cnt       = cnt + 2'd1;
            sp        = 1'b0;
          end
          slot[cnt] = em_c[i];
          cnt       = cnt + 2'd1;
          os        = 1'b1;
        end
      end
    end
  end

  always_comb begin
    q_wdata.data = {slot[2], slot[1], slot[0]};
    q_wdata.eos  = in_is_last;
    q_wdata.bare = in_is_last && (cnt == 2'd0);
    q_wdata.cnt  = (cnt == 2'd0) ? 2'd1 : cnt;
    q_push       = accept && ((cnt != 2'd0) || in_is_last);
  end

  always_comb begin
    lead_pending_nxt   = lead_pending_r;
    space_pending_nxt  = space_pending_r;
    output_started_nxt = output_started_r;
    if (accept) begin
      if (in_is_last) begin
        lead_pending_nxt   = 1'b0;
        space_pending_nxt  = 1'b0;
        output_started_nxt = 1'b0;
      end else begin
        lead_pending_nxt   = lead_hold;
        space_pending_nxt  = sp;
        output_started_nxt = os;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_pending_r   <= 1'b0;
      space_pending_r  <= 1'b0;
      output_started_r <= 1'b0;
    end else begin
      lead_pending_r   <= lead_pending_nxt;
      space_pending_r  <= space_pending_nxt;
      output_started_r <= output_started_nxt;
    end
  end

  // The end of a string leaves no fold state behind.
  a_clear_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_is_last |=> !lead_pending_r && !space_pending_r && !output_started_r)
    else $error("fold state not cleared after end of string");

  // A pending space exists only after output has started.
  a_space_needs_start: assert property (@(posedge clk) disable iff (!rst_n)
    space_pending_r |-> output_started_r)
    else $error("space pending before any output");

endmodule

`default_nettype wire

// File: rtl/afsc_queue.sv
// Short queue of result groups between the front and the back.
// Depends on afsc_pkg.
`default_nettype none

module afsc_queue (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire afsc_pkg::afsc_group_t wdata,
  output logic                       full,
  input  wire logic                  pop,
  output logic                       not_empty,
  output afsc_pkg::afsc_group_t      rdata
);
  import afsc_pkg::*;

  afsc_group_t       mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign full      = (cnt_r == QCNT_W'(QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign rdata     = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (do_push && !do_pop) cnt_nxt = cnt_r + QCNT_W'(1);
    else if (do_pop && !do_push) cnt_nxt = cnt_r - QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wdata;
  end

  // Pushing into a full queue would lose a group.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");

endmodule

`default_nettype wire

// File: rtl/afsc_back.sv
// Back part: sends the results of the head group one per cycle while out_ready is high.
// Depends on afsc_pkg.
`default_nettype none

module afsc_back (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  q_not_empty,
  input  wire afsc_pkg::afsc_group_t q_rdata,
  output logic                       q_pop,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [7:0]                 out_byte,
  output logic                       out_byte_valid,
  output logic                       out_end_of_string
);
  import afsc_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic       last_slot;
  logic       out_accept;

  assign out_valid  = q_not_empty;
  assign out_accept = out_valid && out_ready;
  assign last_slot  = (idx_r == (q_rdata.cnt - 2'd1));
  assign q_pop      = out_accept && last_slot;

  always_comb begin
    case (idx_r)
      2'd0:    out_byte = q_rdata.data[0];
      2'd1:    out_byte = q_rdata.data[1];
      default: out_byte = q_rdata.data[2];
    endcase
    out_byte_valid    = !q_rdata.bare;
    out_end_of_string = q_rdata.eos && last_slot;
  end

  always_comb begin
    idx_nxt = idx_r;
    if (out_accept) idx_nxt = last_slot ? 2'd0 : idx_r + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

  // The slot index stays within the head group.
  a_idx_in_group: assert property (@(posedge clk) disable iff (!rst_n)
    q_not_empty |-> (idx_r < q_rdata.cnt))
    else $error("slot index beyond head group");

  // A bare end marker is a single result that closes the string.
  a_bare_shape: assert property (@(posedge clk) disable iff (!rst_n)
    q_not_empty && q_rdata.bare |-> (q_rdata.cnt == 2'd1) && q_rdata.eos)
    else $error("malformed bare end marker");

endmodule

`default_nettype wire

// File: rtl/accent_fold_space_collapse_core.sv
// Each byte's results are written as one group into the queue's registers and are offered
// from there once earlier groups have left. Throughput: one input byte per cycle while the
// four-group queue has room; results leave one per cycle while the consumer is ready.
// The output port, one result per cycle when the consumer is ready, sets the sustained rate.
// Reset (rst_n low, synchronous) clears the fold state, the queue and the slot index.
`default_nettype none

module accent_fold_space_collapse_core (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_is_last,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_byte_valid,
  output logic            out_end_of_string
);
  import afsc_pkg::*;

  // The front folds each request at once and writes all of its results as one
  // group into the queue. Bytes that cause no result (a held lead byte, a space
  // absorbed by the collapser) are accepted and skip the queue unless they end a string.
  logic        q_push;
  logic        q_full;
  logic        q_pop;
  logic        q_not_empty;
  afsc_group_t q_wdata;
  afsc_group_t q_rdata;

  afsc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .in_is_last (in_is_last),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_wdata    (q_wdata)
  );

  // The queue lets the front keep taking requests while the back is stalled
  // by the consumer or busy sending a multi-result group.
  afsc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .rdata     (q_rdata)
  );

  // The back walks the head group slot by slot and releases it after the last one.
  afsc_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_not_empty       (q_not_empty),
    .q_rdata           (q_rdata),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_byte          (out_byte),
    .out_byte_valid    (out_byte_valid),
    .out_end_of_string (out_end_of_string)
  );

endmodule

`default_nettype wire

// File: tb/fold_key_checker.sv
// Checker for the accent-folding, space-collapsing key generator.
// Watches the request and result channels, predicts the folded key and compares results.
// Depends on afsc_pkg for the byte constants.

module fold_key_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_is_last,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_byte,
  input  logic       out_byte_valid,
  input  logic       out_end_of_string,
  output int         fail_count,
  output int         pending_results
);
  import afsc_pkg::*;

  localparam logic [7:0] LET_A     = "a";
  localparam logic [7:0] LET_C     = "c";
  localparam logic [7:0] LET_E     = "e";
  localparam logic [7:0] LET_I     = "i";
  localparam logic [7:0] LET_N     = "n";
  localparam logic [7:0] LET_O     = "o";
  localparam logic [7:0] LET_U     = "u";
  localparam logic [7:0] NO_LETTER = 8'h00;

  typedef struct packed {
    logic [7:0] ch;
    logic       has_byte;
    logic       eos;
  } key_result_t;

  key_result_t key_q[$];

  logic lead_held;
  logic gap_held;
  logic key_begun;
  int   err_total;

  initial begin
    err_total = 0;
    lead_held = 1'b0;
    gap_held  = 1'b0;
    key_begun = 1'b0;
  end

  // Upper and lower case accents share the low five bits of the second byte.
  function automatic logic [7:0] base_letter(input logic [7:0] d);
    logic [7:0] r;
    r = NO_LETTER;
    if (d[7:6] == 2'b10) begin
      case (d[4:0])
        5'h00, 5'h01, 5'h02, 5'h03, 5'h04, 5'h05: r = LET_A;
        5'h07:                                    r = LET_C;
        5'h08, 5'h09, 5'h0A, 5'h0B:               r = LET_E;
        5'h0C, 5'h0D, 5'h0E, 5'h0F:               r = LET_I;
        5'h11:                                    r = LET_N;
        5'h12, 5'h13, 5'h14, 5'h15, 5'h16:        r = LET_O;
        5'h19, 5'h1A, 5'h1B, 5'h1C:               r = LET_U;
        default:                                  r = NO_LETTER;
      endcase
    end
    return r;
  endfunction

  function automatic logic [7:0] fold_alone(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= UPPER_A && c <= UPPER_Z) r = c | 8'h20;
    else if (c == TAB_BYTE || c == CR_BYTE || c == LF_BYTE) r = SPACE_BYTE;
    return r;
  endfunction

  function automatic void add_result(input logic [7:0] c, input logic has_byte);
    key_result_t r;
    r.ch       = c;
    r.has_byte = has_byte;
    r.eos      = 1'b0;
    key_q.insert(key_q.size(), r);
  endfunction

  // Spaces are held back until a later non-space byte shows they are inner spaces.
  function automatic void collapse(input logic [7:0] c);
    if (c == SPACE_BYTE) begin
      if (key_begun) gap_held = 1'b1;
    end else begin
      if (gap_held) begin
        add_result(SPACE_BYTE, 1'b1);
        gap_held = 1'b0;
      end
      add_result(c, 1'b1);
      key_begun = 1'b1;
    end
  endfunction

  function automatic void predict_key(input logic [7:0] c, input logic last);
    int          n_before;
    logic        paired;
    logic [7:0]  base;
    n_before = key_q.size();
    paired   = 1'b0;
    if (lead_held) begin
      lead_held = 1'b0;
      base      = base_letter(c);
      if (base != NO_LETTER) begin
        collapse(base);
        paired = 1'b1;
      end else begin
        collapse(LEAD_BYTE);
      end
    end
    if (!paired) begin
      if (c == LEAD_BYTE && !last) lead_held = 1'b1;
      else collapse(fold_alone(c));
    end
    if (last) begin
      if (key_q.size() == n_before) add_result(8'h00, 1'b0);
      key_q[key_q.size() - 1].eos = 1'b1;
      lead_held = 1'b0;
      gap_held  = 1'b0;
      key_begun = 1'b0;
    end
  endfunction

  always @(posedge clk) begin
    key_result_t e;
    if (!rst_n) begin
      key_q.delete();
      lead_held = 1'b0;
      gap_held  = 1'b0;
      key_begun = 1'b0;
    end else begin
      if (in_valid && in_ready) predict_key(in_byte, in_is_last);
      if (out_valid && out_ready) begin
        if (key_q.size() == 0) begin
          $error("unexpected result: out_byte %0h byte_valid %0b end_of_string %0b",
                 out_byte, out_byte_valid, out_end_of_string);
          err_total++;
        end else begin
          e = key_q.pop_front();
          if (out_byte !== e.ch) begin
            $error("out_byte: expected %0h, got %0h", e.ch, out_byte);
            err_total++;
          end
          if (out_byte_valid !== e.has_byte) begin
            $error("out_byte_valid: expected %0b, got %0b", e.has_byte, out_byte_valid);
            err_total++;
          end
          if (out_end_of_string !== e.eos) begin
            $error("out_end_of_string: expected %0b, got %0b", e.eos, out_end_of_string);
            err_total++;
          end
        end
      end
    end
    pending_results <= key_q.size();
    fail_count      <= err_total;
  end

endmodule

// File: tb/tb.sv
// Top of the testbench for accent_fold_space_collapse_core.
// Drives byte requests and result backpressure; fold_key_checker does the checking.
// Depends on afsc_pkg, the core and fold_key_checker.

module tb;
  import afsc_pkg::*;

  logic       clk;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte   = 8'h00;
  logic       in_is_last = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_byte_valid;
  logic       out_end_of_string;

  int fail_count;
  int pending_results;

  // Idle chances in percent, changed between phases by the stimulus process.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int sent_in_phase = 0;

  accent_fold_space_collapse_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte          (in_byte),
    .in_is_last       (in_is_last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_byte_valid   (out_byte_valid),
    .out_end_of_string(out_end_of_string)
  );

  fold_key_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte          (in_byte),
    .in_is_last       (in_is_last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_byte_valid   (out_byte_valid),
    .out_end_of_string(out_end_of_string),
    .fail_count       (fail_count),
    .pending_results  (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The receiver draws a fresh ready every cycle, so stalls land on every
  // phase of a multi-result request, including the middle of a group.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // One byte request. Optional idle cycles come first with valid low; once
  // valid rises it stays high with a stable payload until accepted. Only one
  // nonblocking write to in_valid happens per clock edge.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_byte    <= b;
    in_is_last <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_in_phase++;
  endtask

  // One random string. Most strings are made of pieces that reach the
  // interesting paths: letters of both cases, whitespace runs, accent pairs
  // (mapped or not), printable ASCII bytes and arbitrary bytes. The rest is
  // pure noise with no structure at all. A few strings end on a lone lead byte.
  task automatic send_string();
    logic [7:0] s[$];
    logic [7:0] x;
    int         pieces;
    int         kind;
    int         n;
    if ($urandom_range(99) < 15) begin
      n = $urandom_range(1, 6);
      repeat (n) s.insert(s.size(), 8'($urandom_range(255)));
    end else begin
      pieces = $urandom_range(1, 10);
      repeat (pieces) begin
        kind = $urandom_range(99);
        if (kind < 35) begin
          x = UPPER_A + 8'($urandom_range(25));
          if ($urandom_range(1) == 1) x = x | 8'h20;
          s.insert(s.size(), x);
        end else if (kind < 50) begin
          n = $urandom_range(1, 3);
          repeat (n) begin
            case ($urandom_range(5))
              0:       s.insert(s.size(), TAB_BYTE);
              1:       s.insert(s.size(), CR_BYTE);
              2:       s.insert(s.size(), LF_BYTE);
              default: s.insert(s.size(), SPACE_BYTE);
            endcase
          end
        end else if (kind < 68) begin
          // Second byte anywhere in the continuation range: mostly mapped.
          s.insert(s.size(), LEAD_BYTE);
          s.insert(s.size(), 8'h80 | 8'($urandom_range(63)));
        end else if (kind < 78) begin
          s.insert(s.size(), LEAD_BYTE);
          s.insert(s.size(), 8'($urandom_range(255)));
        end else if (kind < 90) begin
          s.insert(s.size(), 8'($urandom_range(8'h21, 8'h7E)));
        end else begin
          s.insert(s.size(), 8'($urandom_range(255)));
        end
      end
      if ($urandom_range(99) < 5) s.insert(s.size(), LEAD_BYTE);
    end
    foreach (s[i]) send_byte(s[i], i == s.size() - 1);
  endtask

  task automatic random_phase(input int send_pct, input int recv_pct, input int items);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    sent_in_phase = 0;
    while (sent_in_phase < items) send_string();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 14;
    recv_idle_pct = 72;

    // Leading whitespace dropped, upper case folded, CR/LF collapsed to a
    // single inner space, and a string ending in a space that sends nothing
    // on its final byte, so it closes with a bare end marker.
    send_byte(SPACE_BYTE, 1'b0);
    send_byte(TAB_BYTE, 1'b0);
    send_byte(UPPER_A, 1'b0);
    send_byte(CR_BYTE, 1'b0);
    send_byte(LF_BYTE, 1'b0);
    send_byte(UPPER_Z, 1'b0);
    send_byte(SPACE_BYTE, 1'b1);

    // Mapped pairs at both ends of the table, an unmapped pair, a lead byte
    // followed by another lead byte, then NUL and 0xFF passing through.
    send_byte(LEAD_BYTE, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(LEAD_BYTE, 1'b0);
    send_byte(8'hBC, 1'b0);
    send_byte(LEAD_BYTE, 1'b0);
    send_byte(UPPER_A, 1'b0);
    send_byte(LEAD_BYTE, 1'b0);
    send_byte(LEAD_BYTE, 1'b0);
    send_byte(8'h91, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);

    // A lead byte as the whole string goes out unchanged.
    send_byte(LEAD_BYTE, 1'b1);
    // A string of only a space yields an empty key.
    send_byte(SPACE_BYTE, 1'b1);
    // Mapped second byte as the final byte of a string.
    send_byte(LEAD_BYTE, 1'b0);
    send_byte(8'hA7, 1'b1);

    random_phase(14, 72, 160);
    random_phase(72, 14, 160);
    random_phase(0, 0, 160);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    // Any stray result from the core would show up within this tail.
    repeat (20) @(posedge clk);

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run with the heaviest stalls.
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule
